FILE: hdl/rmst_pkg.sv
// Shared types and constants for the range-minimum segment tree.
package rmst_pkg;

    localparam int KEY_W = 64;
    localparam int CFG_W = 11;
    localparam int POS_W = 10;

    typedef logic signed [KEY_W-1:0] t_key;

    localparam t_key KEY_LARGEST = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic [CFG_W-1:0] ELEM_COUNT_RESET = 11'd1024;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [1:0] {
        JOB_WRITE,
        JOB_QUERY,
        JOB_REJECT,
        JOB_EMPTY
    } t_job_kind;

    typedef struct packed {
        logic      start;
        t_job_kind kind;
    } t_job_ctl;

endpackage

FILE: hdl/rmst_ram.sv
// Node store: one write port, two registered read ports.
module rmst_ram import rmst_pkg::*; #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_key          i_wr_data,
    input  logic [AW-1:0] i_rd_addr_a,
    input  logic [AW-1:0] i_rd_addr_b,
    output t_key          o_rd_data_a,
    output t_key          o_rd_data_b
);

    t_key mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data_a <= mem[i_rd_addr_a];
        o_rd_data_b <= mem[i_rd_addr_b];
    end

endmodule

FILE: hdl/rmst_seq.sv
// Tree walker: clearing pass, leaf-to-root update and bottom-up range query.
module rmst_seq import rmst_pkg::*; #(
    parameter int MAX_ELEMENTS = 1024
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  t_job_ctl                                    i_job,
    input  logic [$clog2(2*MAX_ELEMENTS)-1:0]           i_leaf,
    input  t_key                                        i_key,
    input  logic [$clog2(2*MAX_ELEMENTS+1)-1:0]         i_l,
    input  logic [$clog2(2*MAX_ELEMENTS+1)-1:0]         i_r,
    output logic                                        o_busy,
    output logic                                        o_done,
    output t_key                                        o_minimum,
    output logic                                        o_no_overlap,
    output logic                                        o_rejected
);

    localparam int DEPTH = 2 * MAX_ELEMENTS;
    localparam int AW    = $clog2(2 * MAX_ELEMENTS);
    localparam int NW    = $clog2(2 * MAX_ELEMENTS + 1);
    localparam logic [AW-1:0] LAST_NODE = AW'(2 * MAX_ELEMENTS - 1);
    localparam logic [AW-1:0] ROOT      = AW'(1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_WLEAF,
        S_WUP,
        S_QRUN
    } t_state;

    t_state        r_state;
    logic [AW-1:0] r_clr_addr;
    logic [AW-1:0] r_node;
    t_key          r_cur;
    logic [NW-1:0] r_l;
    logic [NW-1:0] r_r;
    t_key          r_res;
    logic          r_take_a;
    logic          r_take_b;
    logic          r_done;
    t_key          r_minimum;
    logic          r_no_overlap;
    logic          r_rejected;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_key          wr_data;
    logic [AW-1:0] rd_addr_a;
    logic [AW-1:0] rd_addr_b;
    t_key          rd_data_a;
    t_key          rd_data_b;

    logic [AW-1:0] parent;
    t_key          cur_up;
    logic          l_live;
    logic [NW-1:0] n_l;
    logic [NW-1:0] n_r;
    logic [NW-1:0] dec_r;
    t_key          sel_a;
    t_key          sel_b;
    t_key          acc;

    rmst_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .i_rd_addr_a (rd_addr_a),
        .i_rd_addr_b (rd_addr_b),
        .o_rd_data_a (rd_data_a),
        .o_rd_data_b (rd_data_b)
    );

    always_comb begin
        parent = r_node >> 1;
        cur_up = (r_cur <= rd_data_a) ? r_cur : rd_data_a;

        l_live = (r_l < r_r);
        n_l    = (r_l >> 1) + NW'(r_l[0]);
        n_r    = r_r >> 1;
        dec_r  = r_r - NW'(1);

        // fold both taken nodes into the running minimum with parallel compares
        sel_a = r_take_a ? rd_data_a : KEY_LARGEST;
        sel_b = r_take_b ? rd_data_b : KEY_LARGEST;
        if ((r_res <= sel_a) && (r_res <= sel_b)) begin
            acc = r_res;
        end else if (sel_a <= sel_b) begin
            acc = sel_a;
        end else begin
            acc = sel_b;
        end

        wr_en     = 1'b0;
        wr_addr   = r_node;
        wr_data   = r_cur;
        rd_addr_a = r_l[AW-1:0];
        rd_addr_b = dec_r[AW-1:0];

        case (r_state)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr_addr;
                wr_data = KEY_LARGEST;
            end
            S_WLEAF: begin
                wr_en     = 1'b1;
                rd_addr_a = r_node ^ ROOT;
            end
            S_WUP: begin
                // parent = min(fresh child, sibling); fetch the next sibling alongside
                wr_en     = 1'b1;
                wr_addr   = parent;
                wr_data   = cur_up;
                rd_addr_a = parent ^ ROOT;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_take_a   <= 1'b0;
            r_take_b   <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == LAST_NODE) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_job.start) begin
                        r_node   <= i_leaf;
                        r_cur    <= i_key;
                        r_l      <= i_l;
                        r_r      <= i_r;
                        r_res    <= KEY_LARGEST;
                        r_take_a <= 1'b0;
                        r_take_b <= 1'b0;
                        case (i_job.kind)
                            JOB_WRITE: begin
                                r_state <= S_WLEAF;
                            end
                            JOB_QUERY: begin
                                r_state <= S_QRUN;
                            end
                            JOB_REJECT: begin
                                r_done       <= 1'b1;
                                r_minimum    <= '0;
                                r_no_overlap <= 1'b0;
                                r_rejected   <= 1'b1;
                            end
                            JOB_EMPTY: begin
                                r_done       <= 1'b1;
                                r_minimum    <= KEY_LARGEST;
                                r_no_overlap <= 1'b1;
                                r_rejected   <= 1'b0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_WLEAF: begin
                    r_state <= S_WUP;
                end
                S_WUP: begin
                    r_node <= parent;
                    r_cur  <= cur_up;
                    if (parent == ROOT) begin
                        r_state      <= S_IDLE;
                        r_done       <= 1'b1;
                        r_minimum    <= '0;
                        r_no_overlap <= 1'b0;
                        r_rejected   <= 1'b0;
                    end
                end
                S_QRUN: begin
                    r_res    <= acc;
                    r_take_a <= l_live && r_l[0];
                    r_take_b <= l_live && r_r[0];
                    r_l      <= n_l;
                    r_r      <= n_r;
                    if (!l_live) begin
                        r_state      <= S_IDLE;
                        r_done       <= 1'b1;
                        r_minimum    <= acc;
                        r_no_overlap <= 1'b0;
                        r_rejected   <= 1'b0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy       = (r_state != S_IDLE);
    assign o_done       = r_done;
    assign o_minimum    = r_minimum;
    assign o_no_overlap = r_no_overlap;
    assign o_rejected   = r_rejected;

    a_no_node0_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && (r_state != S_CLEAR)) |-> (wr_addr != '0))
        else $error("update wrote the unused node zero");

    a_sibling_not_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_WLEAF) || (r_state == S_WUP)) |-> (rd_addr_a != wr_addr))
        else $error("update read and wrote the same node in one cycle");

    a_wup_has_sibling: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WUP) |-> (($past(r_state) == S_WLEAF) || ($past(r_state) == S_WUP)))
        else $error("parent refresh without a sibling read in flight");

    a_reject_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_rejected) |-> ((r_minimum == '0) && !r_no_overlap))
        else $error("rejected write carried query result fields");

endmodule

FILE: hdl/range_minimum_segment_tree_unit.sv
// Range-minimum segment tree: top level with count register and command decode.
//
// After reset the unit runs a clearing pass over every node with busy high;
// config writes are taken during it. A write walks from the leaf to the root
// with one node read-modify-write per cycle, so busy stays high until the root
// is written, and the result strobe follows. A query walks the tree bottom up,
// reading up to two nodes per level from the dual-read node memory: busy stays
// high until the two range ends meet, and the result strobe follows. A rejected
// write or a query that covers no element in use is answered the cycle after
// the transfer. Each result is shown for one cycle with o_done and must be
// taken then.
module range_minimum_segment_tree_unit import rmst_pkg::*; #(
    parameter int MAX_ELEMENTS = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             i_command,
    input  logic [POS_W-1:0] i_position,
    input  t_key             i_value,
    input  logic [POS_W-1:0] i_range_low,
    input  logic [POS_W-1:0] i_range_high,
    output logic             o_done,
    output t_key             o_minimum,
    output logic             o_no_overlap,
    output logic             o_rejected,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(2 * MAX_ELEMENTS);
    localparam int NW = $clog2(2 * MAX_ELEMENTS + 1);
    localparam int XW = (NW > CFG_W) ? NW : CFG_W;

    logic [CFG_W-1:0] r_elem_count;

    logic [XW-1:0] max_x;
    logic [XW-1:0] count_x;
    logic [XW-1:0] used_n;
    logic [XW-1:0] pos_x;
    logic [XW-1:0] lo_x;
    logic [XW-1:0] hi_x;
    logic [XW-1:0] hi_clip;
    logic [XW-1:0] leaf_x;
    logic [XW-1:0] l_x;
    logic [XW-1:0] r_x;
    logic          is_reject;
    logic          is_empty;
    t_job_ctl      job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elem_count <= ELEM_COUNT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_elem_count <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    always_comb begin
        max_x   = XW'(MAX_ELEMENTS);
        count_x = XW'(r_elem_count);
        used_n  = (count_x > max_x) ? max_x : count_x;

        pos_x = XW'(i_position);
        lo_x  = XW'(i_range_low);
        hi_x  = XW'(i_range_high);

        is_reject = (pos_x >= used_n);
        is_empty  = (i_range_low > i_range_high) || (lo_x >= used_n);

        // clip the top of the range to the last position in use
        hi_clip = (hi_x > used_n - XW'(1)) ? used_n - XW'(1) : hi_x;

        leaf_x = pos_x + max_x;
        l_x    = lo_x + max_x;
        r_x    = hi_clip + max_x + XW'(1);

        job.start = start && !busy;
        if (i_command == CMD_QUERY) begin
            job.kind = is_empty ? JOB_EMPTY : JOB_QUERY;
        end else begin
            job.kind = is_reject ? JOB_REJECT : JOB_WRITE;
        end
    end

    rmst_seq #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job        (job),
        .i_leaf       (leaf_x[AW-1:0]),
        .i_key        (i_value),
        .i_l          (l_x[NW-1:0]),
        .i_r          (r_x[NW-1:0]),
        .o_busy       (busy),
        .o_done       (o_done),
        .o_minimum    (o_minimum),
        .o_no_overlap (o_no_overlap),
        .o_rejected   (o_rejected)
    );

endmodule

FILE: tb/range_minimum_segment_tree_unit_test.sv
// Self-checking testbench for the range-minimum segment tree unit.
module range_minimum_segment_tree_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rmst_pkg::*;

    localparam int   SLOTS        = 1024;
    localparam t_key KEY_SMALLEST = {1'b1, {(KEY_W-1){1'b0}}};

    typedef struct {
        t_key minimum;
        logic no_overlap;
        logic rejected;
    } t_answer;

    // Keeps element values by position and queues the answer due for each transfer.
    class range_min_board;
        t_key             elems [SLOTS];
        logic [CFG_W-1:0] count;
        t_answer          answers [$];
        int               mismatches;

        function new();
            foreach (elems[i]) elems[i] = KEY_LARGEST;
            count      = ELEM_COUNT_RESET;
            mismatches = 0;
        endfunction

        function int in_use();
            return (int'(count) > SLOTS) ? SLOTS : int'(count);
        endfunction

        function int pending();
            return answers.size();
        endfunction

        function void note_command(logic cmd, logic [POS_W-1:0] pos, t_key val,
                                   logic [POS_W-1:0] lo, logic [POS_W-1:0] hi);
            t_answer a;
            int      n;
            int      top;
            n            = in_use();
            a.minimum    = '0;
            a.no_overlap = 1'b0;
            a.rejected   = 1'b0;
            if (cmd == CMD_WRITE) begin
                if (int'(pos) >= n) a.rejected = 1'b1;
                else elems[pos] = val;
            end else if (lo > hi || int'(lo) >= n) begin
                a.minimum    = KEY_LARGEST;
                a.no_overlap = 1'b1;
            end else begin
                // clip the top of the range to the last position in use
                top       = (int'(hi) > n - 1) ? n - 1 : int'(hi);
                a.minimum = KEY_LARGEST;
                for (int i = int'(lo); i <= top; i++) begin
                    if (elems[i] < a.minimum) a.minimum = elems[i];
                end
            end
            answers.push_back(a);
        endfunction

        function void check_result(t_key m, logic nov, logic rej);
            t_answer a;
            if (answers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result with nothing outstanding: min=%0d nov=%0b rej=%0b",
                             m, nov, rej);
                return;
            end
            a = answers.pop_front();
            if (m !== a.minimum || nov !== a.no_overlap || rej !== a.rejected) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp min=%0d nov=%0b rej=%0b, got min=%0d nov=%0b rej=%0b",
                             a.minimum, a.no_overlap, a.rejected, m, nov, rej);
            end
        endfunction
    endclass

    logic             i_clk        = 1'b0;
    logic             i_rst_n      = 1'b0;
    logic             start        = 1'b0;
    logic             i_command    = CMD_WRITE;
    logic [POS_W-1:0] i_position   = '0;
    t_key             i_value      = '0;
    logic [POS_W-1:0] i_range_low  = '0;
    logic [POS_W-1:0] i_range_high = '0;
    logic             i_cfg_valid  = 1'b0;
    logic [CFG_W-1:0] i_cfg_data   = '0;
    logic             busy;
    logic             o_done;
    t_key             o_minimum;
    logic             o_no_overlap;
    logic             o_rejected;
    logic             o_cfg_ready;

    range_min_board board;

    range_minimum_segment_tree_unit #(
        .MAX_ELEMENTS(SLOTS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_command    (i_command),
        .i_position   (i_position),
        .i_value      (i_value),
        .i_range_low  (i_range_low),
        .i_range_high (i_range_high),
        .o_done       (o_done),
        .o_minimum    (o_minimum),
        .o_no_overlap (o_no_overlap),
        .o_rejected   (o_rejected),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) board.check_result(o_minimum, o_no_overlap, o_rejected);
    end

    initial begin
        #5ms;
        $display("range_minimum_segment_tree_unit verification failed");
        $finish;
    end

    // Hold the command until the transfer, then record it.
    task automatic send_item(logic cmd, logic [POS_W-1:0] pos, t_key val,
                             logic [POS_W-1:0] lo, logic [POS_W-1:0] hi);
        start        <= 1'b1;
        i_command    <= cmd;
        i_position   <= pos;
        i_value      <= val;
        i_range_low  <= lo;
        i_range_high <= hi;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        board.note_command(cmd, pos, val, lo, hi);
    endtask

    task automatic write_elem(int pos, t_key val);
        send_item(CMD_WRITE, POS_W'(pos), val, POS_W'($urandom), POS_W'($urandom));
    endtask

    task automatic query_range(int lo, int hi);
        send_item(CMD_QUERY, POS_W'($urandom), {$urandom, $urandom}, POS_W'(lo), POS_W'(hi));
    endtask

    // Drop start and hold off until every outstanding answer has come back.
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    task automatic set_count(logic [CFG_W-1:0] cnt);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cnt;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        board.count = cnt;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_key rand_value();
        case ($urandom_range(0, 5))
            0:       return KEY_LARGEST;
            1:       return KEY_SMALLEST;
            2:       return t_key'(longint'($urandom_range(0, 200)) - 64'sd100);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] rand_count();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return CFG_W'(1);
            2:       return CFG_W'(2);
            3:       return CFG_W'($urandom_range(3, 64));
            6:       return CFG_W'(SLOTS);
            7:       return CFG_W'($urandom_range(SLOTS + 1, 2047));
            default: return CFG_W'($urandom_range(1, SLOTS));
        endcase
    endfunction

    task automatic run_segment(int items, int idle_pct);
        int n;
        int lo;
        int hi;
        int pos;
        n = board.in_use();
        for (int k = 0; k < items; k++) begin
            if ($urandom_range(0, 299) == 0) begin
                wait_drained();
            end else if ($urandom_range(0, 99) < idle_pct) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end
            if ($urandom_range(0, 1) == 0) begin
                if (n > 0 && $urandom_range(0, 9) != 0) pos = $urandom_range(0, n - 1);
                else pos = $urandom_range(0, SLOTS - 1);
                write_elem(pos, rand_value());
            end else begin
                lo = $urandom_range(0, SLOTS - 1);
                hi = $urandom_range(0, SLOTS - 1);
                case ($urandom_range(0, 9))
                    0: ;
                    1: begin
                        lo = $urandom_range(1, SLOTS - 1);
                        hi = $urandom_range(0, lo - 1);
                    end
                    2: begin
                        if (n < SLOTS) begin
                            lo = $urandom_range(n, SLOTS - 1);
                            hi = $urandom_range(lo, SLOTS - 1);
                        end
                    end
                    default: begin
                        if (n > 0) begin
                            lo = $urandom_range(0, n - 1);
                            if ($urandom_range(0, 1) == 0) hi = lo + $urandom_range(0, 7);
                            else hi = $urandom_range(lo, SLOTS - 1);
                            if (hi > SLOTS - 1) hi = SLOTS - 1;
                        end
                    end
                endcase
                query_range(lo, hi);
            end
        end
    endtask

    initial begin
        board = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // fresh store, extreme values, bit patterns, clipping and empty ranges
        query_range(0, 1023);
        write_elem(0, KEY_SMALLEST);
        write_elem(1023, KEY_LARGEST);
        write_elem(512, t_key'(-1));
        write_elem(5, 64'h5555_5555_5555_5555);
        write_elem(6, 64'hAAAA_AAAA_AAAA_AAAA);
        query_range(0, 1023);
        query_range(1, 1023);
        query_range(1023, 1023);
        query_range(10, 3);
        query_range(512, 512);
        query_range(7, 511);
        wait_drained();
        set_count(CFG_W'(0));
        write_elem(0, t_key'(7));
        query_range(0, 0);
        wait_drained();
        set_count(CFG_W'(2047));
        write_elem(1023, t_key'(-5));
        query_range(1000, 1023);
        wait_drained();
        set_count(CFG_W'(1));
        write_elem(1, t_key'(3));
        write_elem(0, t_key'(42));
        query_range(0, 1023);
        query_range(1, 5);
        wait_drained();
        set_count(CFG_W'(100));
        query_range(50, 1023);
        query_range(100, 200);
        query_range(0, 99);
        wait_drained();
        set_count(CFG_W'(SLOTS));
        query_range(0, 1023);

        for (int phase = 0; phase < 3; phase++) begin
            for (int seg = 0; seg < 5; seg++) begin
                wait_drained();
                set_count(rand_count());
                run_segment(130, (phase == 0) ? 8 : (phase == 1) ? 46 : 0);
            end
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("range_minimum_segment_tree_unit verification clean");
        end else begin
            $display("range_minimum_segment_tree_unit verification failed");
        end
        $finish;
    end

endmodule

FILE: range_minimum_segment_tree_unit.f
hdl/rmst_pkg.sv
hdl/rmst_ram.sv
hdl/rmst_seq.sv
hdl/range_minimum_segment_tree_unit.sv
tb/range_minimum_segment_tree_unit_test.sv
